// File: design/bezier_curve_evaluator_defines.svh
// Assertion macros shared by the evaluator modules.
`ifndef BEZIER_CURVE_EVALUATOR_DEFINES_SVH
`define BEZIER_CURVE_EVALUATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define BCE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BCE_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define BCE_ASSERT(label, clk, rst, prop, msg)
`define BCE_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

// File: design/bce_pkg.sv
`timescale 1ns / 1ps

package bce_pkg;

   localparam int MAX_CONTROL_POINTS_DEF = 16;
   localparam int MAX_DIMS_DEF           = 4;
   localparam int RESULT_LIMIT           = 4;

   localparam int FRAC_W     = 24;
   localparam int WEIGHT_W   = 26;
   localparam int U_W        = 25;
   localparam int PARAM_W    = 17;
   localparam int COORD_W    = 32;
   localparam int MUL_A_W    = 27;
   localparam int PROD_W     = MUL_A_W + COORD_W;
   localparam int CC_W       = 5;
   localparam int DC_W       = 3;
   localparam int DIM_CNT_W  = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam logic [CC_W-1:0] POINT_COUNT_RESET = CC_W'(4);
   localparam logic [DC_W-1:0] DIM_COUNT_RESET   = DC_W'(2);

   localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(65536);

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_POINT_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_COUNT   = CSR_IDX_W'(1);

   typedef enum logic [1:0] {
      MUL_V   = 2'd0,
      MUL_U   = 2'd1,
      MUL_DOT = 2'd2
   } mul_sel_type;

   typedef struct packed {
      logic        load_store;
      logic        start_eval;
      logic        w_init;
      logic        w_read;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        w_write_k;
      logic        carry_load;
      logic        w_write_j;
      logic        dot_read;
      logic        acc_add;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic row_done;
      logic curve_done;
      logic dot_done;
      logic dim_last;
   } sts_type;

endpackage

// File: design/bce_datapath.sv
`timescale 1ns / 1ps
`include "bezier_curve_evaluator_defines.svh"

module bce_datapath #(
   parameter int MAX_CONTROL_POINTS = bce_pkg::MAX_CONTROL_POINTS_DEF,
   parameter int MAX_DIMS           = bce_pkg::MAX_DIMS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bce_pkg::cmd_type                    cmd,
   output bce_pkg::sts_type                    sts,
   input  logic [bce_pkg::CC_W-1:0]            point_count,
   input  logic [bce_pkg::DC_W-1:0]            dim_count,
   input  logic [3:0]                          req_point_index,
   input  logic [1:0]                          req_coord_index,
   input  logic signed [bce_pkg::COORD_W-1:0]  req_coord_value,
   input  logic [bce_pkg::PARAM_W-1:0]         req_param_u,
   input  logic                                req_batch_end,
   output logic                                rsp_valid,
   output logic signed [bce_pkg::COORD_W-1:0]  rsp_point_value,
   output logic [1:0]                          rsp_out_dim,
   output logic                                rsp_last_dim,
   output logic                                rsp_batch_done
);

   localparam int KW      = $clog2(MAX_CONTROL_POINTS + 1);
   localparam int WIW     = $clog2(MAX_CONTROL_POINTS);
   localparam int DEPTH   = MAX_CONTROL_POINTS * MAX_DIMS;
   localparam int SAW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DIM_LIM = (MAX_DIMS < bce_pkg::RESULT_LIMIT) ? MAX_DIMS
                                                               : bce_pkg::RESULT_LIMIT;
   localparam int ACC_W   = bce_pkg::PROD_W + WIW + 1;
   localparam int RW      = ACC_W - bce_pkg::FRAC_W;
   localparam int WW      = bce_pkg::WEIGHT_W;
   localparam int CW      = bce_pkg::COORD_W;
   localparam int PW      = bce_pkg::PROD_W;
   localparam int FW      = bce_pkg::FRAC_W;
   localparam int DCW     = bce_pkg::DIM_CNT_W;

   localparam logic [WW-1:0]        WEIGHT_ONE = WW'(1) << FW;
   localparam logic [bce_pkg::U_W-1:0] U_ONE   = bce_pkg::U_W'(1) << FW;

   logic [WW-1:0]  w_mem_ff [MAX_CONTROL_POINTS];
   logic [CW-1:0]  store_mem_ff [DEPTH];

   logic [WW-1:0]  w_rd_ff;
   logic signed [CW-1:0] store_rd_ff;

   logic [bce_pkg::U_W-1:0] u_ff, u_in, v_ff, v_in;
   logic [KW-1:0]  n_ff, n_in, j_ff, j_in, k_ff, k_in;
   logic [DCW-1:0] dims_ff, dims_in, d_ff, d_in;
   logic           bend_ff, bend_in;
   logic [WW-1:0]  carry_ff, carry_in;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]  rsp_value_ff, rsp_value_in;
   logic [1:0]     rsp_dim_ff, rsp_dim_in;
   logic           rsp_last_ff, rsp_last_in;
   logic           rsp_bend_ff, rsp_bend_in;

   logic [bce_pkg::PARAM_W-1:0] u_sat;
   logic signed [bce_pkg::MUL_A_W-1:0] mul_a;
   logic signed [CW-1:0]   mul_b;
   logic [PW-1:0]          prod_rnd;
   logic [WW-1:0]          weight_rnd;
   logic                   w_we;
   logic [WIW-1:0]         w_waddr;
   logic [WW-1:0]          w_wdata;
   logic [SAW-1:0]         st_waddr, st_raddr;
   logic                   st_we;
   logic signed [ACC_W-1:0] acc_rnd;
   logic [RW-1:0]          r_bits;
   logic [RW-32:0]         r_top;

   assign u_sat = (req_param_u > bce_pkg::PARAM_ONE) ? bce_pkg::PARAM_ONE : req_param_u;
   assign prod_rnd   = PW'(prod_ff + PW'(WEIGHT_ONE >> 1));
   assign weight_rnd = prod_rnd[FW +: WW];

   always_comb begin
      case (cmd.mul_sel)
         bce_pkg::MUL_V: begin
            mul_a = bce_pkg::MUL_A_W'(v_ff);
            mul_b = CW'(w_rd_ff);
         end
         bce_pkg::MUL_U: begin
            mul_a = bce_pkg::MUL_A_W'(u_ff);
            mul_b = CW'(w_rd_ff);
         end
         bce_pkg::MUL_DOT: begin
            mul_a = bce_pkg::MUL_A_W'(w_rd_ff);
            mul_b = store_rd_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      w_we    = cmd.w_init | cmd.w_write_k | cmd.w_write_j;
      w_waddr = '0;
      w_wdata = WEIGHT_ONE;
      if (cmd.w_write_k) begin
         w_waddr = k_ff[WIW-1:0];
         w_wdata = WW'(carry_ff + weight_rnd);
      end else if (cmd.w_write_j) begin
         w_waddr = j_ff[WIW-1:0];
         w_wdata = carry_ff;
      end
   end

   assign st_we    = cmd.load_store && (int'(req_point_index) < MAX_CONTROL_POINTS)
                     && (int'(req_coord_index) < MAX_DIMS);
   assign st_waddr = SAW'(int'(req_point_index) * MAX_DIMS + int'(req_coord_index));
   assign st_raddr = SAW'(int'(k_ff) * MAX_DIMS + int'(d_ff));

   always_ff @(posedge clock) begin
      if (w_we) begin
         w_mem_ff[w_waddr] <= w_wdata;
      end
      if (cmd.w_read || cmd.dot_read) begin
         w_rd_ff <= w_mem_ff[k_ff[WIW-1:0]];
      end
      if (st_we) begin
         store_mem_ff[st_waddr] <= req_coord_value;
      end
      if (cmd.dot_read) begin
         store_rd_ff <= store_mem_ff[st_raddr];
      end
   end

   assign acc_rnd = acc_ff + ACC_W'(WEIGHT_ONE >> 1);
   assign r_bits  = acc_rnd[ACC_W-1:FW];
   assign r_top   = r_bits[RW-1:31];

   always_comb begin
      u_in = u_ff;
      v_in = v_ff;
      n_in = n_ff;
      dims_in = dims_ff;
      bend_in = bend_ff;
      j_in = j_ff;
      k_in = k_ff;
      d_in = d_ff;
      carry_in = carry_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_dim_in = rsp_dim_ff;
      rsp_last_in = rsp_last_ff;
      rsp_bend_in = rsp_bend_ff;

      if (cmd.start_eval) begin
         u_in = {u_sat, 8'b0};
         v_in = U_ONE - {u_sat, 8'b0};
         bend_in = req_batch_end;
         if (point_count < bce_pkg::CC_W'(2)) begin
            n_in = KW'(2);
         end else if (int'(point_count) > MAX_CONTROL_POINTS) begin
            n_in = KW'(MAX_CONTROL_POINTS);
         end else begin
            n_in = KW'(point_count);
         end
         if (dim_count == '0) begin
            dims_in = DCW'(1);
         end else if (int'(dim_count) > DIM_LIM) begin
            dims_in = DCW'(DIM_LIM);
         end else begin
            dims_in = DCW'(dim_count);
         end
      end
      if (cmd.w_init) begin
         j_in = KW'(1);
         k_in = '0;
         carry_in = '0;
      end
      if (cmd.mul_en) begin
         prod_in = PW'(mul_a * mul_b);
      end
      if (cmd.carry_load) begin
         carry_in = weight_rnd;
         k_in = KW'(k_ff + KW'(1));
      end
      if (cmd.w_write_j) begin
         j_in = KW'(j_ff + KW'(1));
         k_in = '0;
         carry_in = '0;
         d_in = '0;
         acc_in = '0;
      end
      if (cmd.acc_add) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
         k_in = KW'(k_ff + KW'(1));
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if ((&r_top) || !(|r_top)) begin
            rsp_value_in = r_bits[31:0];
         end else if (r_bits[RW-1]) begin
            rsp_value_in = 32'h8000_0000;
         end else begin
            rsp_value_in = 32'h7FFF_FFFF;
         end
         rsp_dim_in = d_ff[1:0];
         rsp_last_in = sts.dim_last;
         rsp_bend_in = bend_ff;
         acc_in = '0;
         k_in = '0;
         d_in = DCW'(d_ff + DCW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         j_ff <= '0;
         k_ff <= '0;
         d_ff <= '0;
         n_ff <= KW'(2);
         dims_ff <= DCW'(1);
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         j_ff <= j_in;
         k_ff <= k_in;
         d_ff <= d_in;
         n_ff <= n_in;
         dims_ff <= dims_in;
      end
      u_ff <= u_in;
      v_ff <= v_in;
      bend_ff <= bend_in;
      carry_ff <= carry_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      rsp_value_ff <= rsp_value_in;
      rsp_dim_ff <= rsp_dim_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bend_ff <= rsp_bend_in;
   end

   assign sts.row_done   = (KW'(k_ff + KW'(1)) == j_ff);
   assign sts.curve_done = (KW'(j_ff + KW'(1)) == n_ff);
   assign sts.dot_done   = (KW'(k_ff + KW'(1)) == n_ff);
   assign sts.dim_last   = (DCW'(d_ff + DCW'(1)) == dims_ff);

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_value = rsp_value_ff;
   assign rsp_out_dim     = rsp_dim_ff;
   assign rsp_last_dim    = rsp_last_ff;
   assign rsp_batch_done  = rsp_bend_ff;

   `BCE_ASSERT(a_row_end, clock, reset, cmd.w_write_j |-> (k_ff == j_ff), "row end off count")
   `BCE_ASSERT(a_dot_end, clock, reset, cmd.emit |-> (k_ff == n_ff), "dot product short")
   `BCE_ASSERT(a_dim_range, clock, reset, cmd.emit |-> (d_ff < dims_ff), "dimension overrun")

endmodule

// File: design/bce_controller.sv
`timescale 1ns / 1ps
`include "bezier_curve_evaluator_defines.svh"

module bce_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             req_opcode,
   input  bce_pkg::sts_type sts,
   output bce_pkg::cmd_type cmd,
   output logic             busy
);

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_INIT = 11'b000_0000_0010,
      S_RD   = 11'b000_0000_0100,
      S_MV   = 11'b000_0000_1000,
      S_MU   = 11'b000_0001_0000,
      S_CY   = 11'b000_0010_0000,
      S_WJ   = 11'b000_0100_0000,
      S_DRD  = 11'b000_1000_0000,
      S_DMUL = 11'b001_0000_0000,
      S_DACC = 11'b010_0000_0000,
      S_OUT  = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_opcode == bce_pkg::OP_EVAL) begin
                  cmd.start_eval = 1'b1;
                  state_in = S_INIT;
               end else begin
                  cmd.load_store = 1'b1;
               end
            end
         end
         S_INIT: begin
            cmd.w_init = 1'b1;
            state_in = S_RD;
         end
         S_RD: begin
            cmd.w_read = 1'b1;
            state_in = S_MV;
         end
         S_MV: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = bce_pkg::MUL_V;
            state_in = S_MU;
         end
         S_MU: begin
            cmd.w_write_k = 1'b1;
            cmd.mul_en = 1'b1;
            cmd.mul_sel = bce_pkg::MUL_U;
            state_in = S_CY;
         end
         S_CY: begin
            cmd.carry_load = 1'b1;
            state_in = sts.row_done ? S_WJ : S_RD;
         end
         S_WJ: begin
            cmd.w_write_j = 1'b1;
            state_in = sts.curve_done ? S_DRD : S_RD;
         end
         S_DRD: begin
            cmd.dot_read = 1'b1;
            state_in = S_DMUL;
         end
         S_DMUL: begin
            cmd.mul_en = 1'b1;
            cmd.mul_sel = bce_pkg::MUL_DOT;
            state_in = S_DACC;
         end
         S_DACC: begin
            cmd.acc_add = 1'b1;
            state_in = sts.dot_done ? S_OUT : S_DRD;
         end
         S_OUT: begin
            cmd.emit = 1'b1;
            state_in = sts.dim_last ? S_IDLE : S_DRD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   `BCE_ASSERT(a_busy_end, clock, reset, $fell(busy) |-> $past(cmd.emit && sts.dim_last), "early idle")

endmodule

// File: design/bezier_curve_evaluator.sv
`timescale 1ns / 1ps

// Bezier curve evaluator, Bernstein basis.
// Input: start/busy command port. An item transfers when start is high and busy
// is low. opcode 0 loads one Q16.16 coordinate into the control store in that
// cycle and gives no result. opcode 1 evaluates the curve at param_u (Q1.16).
// Output: rsp_valid marks each result for exactly one cycle; one result per
// dimension, in dimension order, last_dim on the final one.
// Configuration: csr_write_enable writes point_count (index 0) or dim_count
// (index 1); write only while busy is low.
// An evaluation with n points and D dimensions builds the weights row by
// row, each recurrence term in the steps read, multiply by v, multiply by u
// and carry, then forms each dot-product term in the steps read, multiply
// and accumulate; one shared multiplier serves both.
// The next item is taken once busy is low again.
// Reset clears the controller and sets the registers to 4 and 2; the control
// store holds no defined value until written. Results cannot be held off.
module bezier_curve_evaluator #(
   parameter int MAX_CONTROL_POINTS = bce_pkg::MAX_CONTROL_POINTS_DEF,
   parameter int MAX_DIMS           = bce_pkg::MAX_DIMS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_opcode,
   input  logic [3:0]                           req_point_index,
   input  logic [1:0]                           req_coord_index,
   input  logic signed [bce_pkg::COORD_W-1:0]   req_coord_value,
   input  logic [bce_pkg::PARAM_W-1:0]          req_param_u,
   input  logic                                 req_batch_end,
   output logic                                 rsp_valid,
   output logic signed [bce_pkg::COORD_W-1:0]   rsp_point_value,
   output logic [1:0]                           rsp_out_dim,
   output logic                                 rsp_last_dim,
   output logic                                 rsp_batch_done,
   input  logic                                 csr_write_enable,
   input  logic [bce_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bce_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   logic [bce_pkg::CC_W-1:0] cc_ff, cc_in;
   logic [bce_pkg::DC_W-1:0] dc_ff, dc_in;
   bce_pkg::cmd_type cmd;
   bce_pkg::sts_type sts;

   always_comb begin
      cc_in = cc_ff;
      dc_in = dc_ff;
      if (csr_write_enable) begin
         case (csr_index)
            bce_pkg::CSR_POINT_COUNT: cc_in = csr_write_data[bce_pkg::CC_W-1:0];
            bce_pkg::CSR_DIM_COUNT:   dc_in = csr_write_data[bce_pkg::DC_W-1:0];
            default: begin
               cc_in = cc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff <= bce_pkg::POINT_COUNT_RESET;
         dc_ff <= bce_pkg::DIM_COUNT_RESET;
      end else begin
         cc_ff <= cc_in;
         dc_ff <= dc_in;
      end
   end

   bce_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .sts        (sts),
      .cmd        (cmd),
      .busy       (busy)
   );

   bce_datapath #(
      .MAX_CONTROL_POINTS (MAX_CONTROL_POINTS),
      .MAX_DIMS           (MAX_DIMS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .point_count     (cc_ff),
      .dim_count       (dc_ff),
      .req_point_index (req_point_index),
      .req_coord_index (req_coord_index),
      .req_coord_value (req_coord_value),
      .req_param_u     (req_param_u),
      .req_batch_end   (req_batch_end),
      .rsp_valid       (rsp_valid),
      .rsp_point_value (rsp_point_value),
      .rsp_out_dim     (rsp_out_dim),
      .rsp_last_dim    (rsp_last_dim),
      .rsp_batch_done  (rsp_batch_done)
   );

endmodule
